// ===== design/i2c3w_pkg.sv =====
// Shared constants for the three-byte I2C write master: phase codes,
// configuration register indexes, widths and reset values. No dependencies.
package i2c3w_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_INDEX_W     = 4;
	localparam int CFG_DATA_W      = 16;
	localparam int TIMING_W        = 16;
	localparam int POLL_W          = 8;
	localparam int PHASE_W         = 4;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SCL_LOW    = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCL_HIGH   = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_HOLD = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT = 4'd3;

	localparam logic [TIMING_W-1:0] SCL_LOW_RST    = 16'd5;
	localparam logic [TIMING_W-1:0] SCL_HIGH_RST   = 16'd5;
	localparam logic [TIMING_W-1:0] START_HOLD_RST = 16'd5;
	localparam logic [POLL_W-1:0]   POLL_LIMIT_RST = 8'd100;

	// bus phases
	localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
	localparam logic [PHASE_W-1:0] PH_START_HIGH = 4'd1;
	localparam logic [PHASE_W-1:0] PH_START_LOW  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_BIT_LOW    = 4'd3;
	localparam logic [PHASE_W-1:0] PH_BIT_HIGH   = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ACK_LOW    = 4'd5;
	localparam logic [PHASE_W-1:0] PH_ACK_POLL   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_STOP_LOW   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_STOP_HIGH  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_DONE       = 4'd9;

	localparam logic [1:0] LAST_BYTE = 2'd2;
	localparam logic [2:0] LAST_BIT  = 3'd7;

endpackage

// ===== design/i2c_three_byte_write_master_core.sv =====
// Top level of the three-byte I2C write master: bus sequencer, timing
// counter and output register. Depends on i2c3w_pkg.

// Open-drain I2C master that sends one write transaction of three bytes
// (address byte as given, register byte, data byte, each MSB first) with a
// start condition, an acknowledge poll after every byte and a stop that is
// always sent. Each input transaction is one bus tick: it carries the
// start request, the three bytes (latched only when a request is taken in
// idle) and the sampled SDA level. Each input transaction yields exactly
// one result transaction with the line drives for that tick plus busy,
// done and write_ok. Rate: one tick per clock while results drain. The sequencer
// state (phase, tick counter, bit and byte counters, shift byte) is
// updated in one registered step per accepted tick, and the result sits in
// an output register, so a new tick is taken whenever that register is
// empty or being drained in the same cycle. Timing registers are 16 bits;
// a value of 0 acts as 1, and values above 2^TIMER_WIDTH saturate there.
// Configuration is written through cfg_valid/cfg_ready, always ready;
// indexes above 3 are dropped.
module i2c_three_byte_write_master_core #(
	parameter int TIMER_WIDTH = i2c3w_pkg::TIMER_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              start_request,
	input  logic [7:0]                        address_byte,
	input  logic [7:0]                        register_byte,
	input  logic [7:0]                        data_byte,
	input  logic                              sda_in,
	// tick result
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              scl_drive_low,
	output logic                              sda_drive_low,
	output logic                              busy_res,
	output logic                              done_res,
	output logic                              write_ok,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2c3w_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [i2c3w_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import i2c3w_pkg::*;

	// counter compare width: wide enough for tick+1 and for 2^TIMER_WIDTH
	localparam int CW = ((TIMER_WIDTH > TIMING_W) ? TIMER_WIDTH : TIMING_W) + 1;
	localparam logic [CW-1:0] CAP = CW'(1) << TIMER_WIDTH;

	// configuration
	logic [TIMING_W-1:0] scl_low_q, scl_high_q, start_hold_q;
	logic [POLL_W-1:0]   poll_limit_q;

	// sequencer state
	logic [PHASE_W-1:0]     phase_q, phase_nxt;
	logic [TIMER_WIDTH-1:0] tick_q, tick_nxt;
	logic [2:0]             bit_q, bit_nxt;
	logic [1:0]             byte_q, byte_nxt;
	logic [7:0]             shift_q, shift_nxt;
	logic [15:0]            held_q, held_nxt;
	logic [POLL_W-1:0]      poll_q, poll_nxt;
	logic                   success_q, success_nxt;

	// result register
	logic out_valid_q;
	logic scl_drive_low_q, sda_drive_low_q, busy_res_q, done_res_q, write_ok_q;
	logic scl_o, sda_o, busy_o, done_o, ok_o;

	// timer
	logic [TIMING_W-1:0] sel_ticks;
	logic [CW-1:0]       lim_ext, tick_inc;
	logic                timer_end;
	logic [TIMER_WIDTH-1:0] tick_step;

	logic [POLL_W-1:0] poll_inc, poll_lim;
	logic              bit_low;
	logic              in_fire;

	assign in_fire   = in_valid & in_ready;
	assign in_ready  = ~out_valid_q | out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_low_q    <= SCL_LOW_RST;
			scl_high_q   <= SCL_HIGH_RST;
			start_hold_q <= START_HOLD_RST;
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCL_LOW:    scl_low_q    <= cfg_data;
				REG_SCL_HIGH:   scl_high_q   <= cfg_data;
				REG_START_HOLD: start_hold_q <= cfg_data;
				REG_POLL_LIMIT: poll_limit_q <= cfg_data[POLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// one shared phase timer; the limit follows the phase
	always_comb begin
		case (phase_q)
			PH_START_HIGH, PH_START_LOW: sel_ticks = start_hold_q;
			PH_BIT_HIGH, PH_STOP_HIGH:   sel_ticks = scl_high_q;
			default:                     sel_ticks = scl_low_q;
		endcase
		lim_ext = (sel_ticks == '0) ? CW'(1) : CW'(sel_ticks);
		if (lim_ext > CAP)
			lim_ext = CAP;
		tick_inc  = CW'(tick_q) + CW'(1);
		timer_end = (tick_inc >= lim_ext);
		tick_step = timer_end ? '0 : tick_inc[TIMER_WIDTH-1:0];
	end

	assign poll_inc = poll_q + POLL_W'(1);
	assign poll_lim = (poll_limit_q == '0) ? POLL_W'(1) : poll_limit_q;
	assign bit_low  = ~shift_q[7];

	always_comb begin
		phase_nxt   = phase_q;
		tick_nxt    = tick_q;
		bit_nxt     = bit_q;
		byte_nxt    = byte_q;
		shift_nxt   = shift_q;
		held_nxt    = held_q;
		poll_nxt    = poll_q;
		success_nxt = success_q;
		scl_o  = 1'b0;
		sda_o  = 1'b0;
		busy_o = 1'b1;
		done_o = 1'b0;
		ok_o   = 1'b0;
		case (phase_q)
			PH_START_HIGH: begin
				tick_nxt = tick_step;
				if (timer_end)
					phase_nxt = PH_START_LOW;
			end
			PH_START_LOW: begin
				sda_o    = 1'b1;
				tick_nxt = tick_step;
				if (timer_end) begin
					byte_nxt  = '0;
					bit_nxt   = '0;
					phase_nxt = PH_BIT_LOW;
				end
			end
			PH_BIT_LOW: begin
				scl_o    = 1'b1;
				sda_o    = bit_low;
				tick_nxt = tick_step;
				if (timer_end)
					phase_nxt = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				sda_o    = bit_low;
				tick_nxt = tick_step;
				if (timer_end) begin
					if (bit_q == LAST_BIT) begin
						phase_nxt = PH_ACK_LOW;
					end else begin
						bit_nxt   = bit_q + 3'd1;
						shift_nxt = {shift_q[6:0], 1'b0};
						phase_nxt = PH_BIT_LOW;
					end
				end
			end
			PH_ACK_LOW: begin
				// SDA keeps the last data bit until SCL is low long enough
				scl_o    = 1'b1;
				sda_o    = bit_low;
				tick_nxt = tick_step;
				if (timer_end) begin
					poll_nxt  = '0;
					phase_nxt = PH_ACK_POLL;
				end
			end
			PH_ACK_POLL: begin
				if (!sda_in) begin
					if (byte_q >= LAST_BYTE) begin
						success_nxt = 1'b1;
						tick_nxt    = '0;
						phase_nxt   = PH_STOP_LOW;
					end else begin
						byte_nxt  = byte_q + 2'd1;
						shift_nxt = (byte_q == 2'd0) ? held_q[15:8] : held_q[7:0];
						bit_nxt   = '0;
						tick_nxt  = '0;
						phase_nxt = PH_BIT_LOW;
					end
				end else begin
					// no acknowledge yet; the counter wrap also aborts
					poll_nxt = poll_inc;
					if (poll_inc == '0 || poll_inc >= poll_lim) begin
						success_nxt = 1'b0;
						tick_nxt    = '0;
						phase_nxt   = PH_STOP_LOW;
					end
				end
			end
			PH_STOP_LOW: begin
				scl_o    = 1'b1;
				tick_nxt = tick_step;
				if (timer_end)
					phase_nxt = PH_STOP_HIGH;
			end
			PH_STOP_HIGH: begin
				sda_o    = 1'b1;
				tick_nxt = tick_step;
				if (timer_end)
					phase_nxt = PH_DONE;
			end
			PH_DONE: begin
				done_o    = 1'b1;
				ok_o      = success_q;
				tick_nxt  = '0;
				phase_nxt = PH_IDLE;
			end
			default: begin
				// idle, and any meaningless code
				busy_o    = 1'b0;
				phase_nxt = PH_IDLE;
				if (start_request) begin
					shift_nxt   = address_byte;
					held_nxt    = {register_byte, data_byte};
					success_nxt = 1'b0;
					bit_nxt     = '0;
					byte_nxt    = '0;
					poll_nxt    = '0;
					tick_nxt    = '0;
					phase_nxt   = PH_START_HIGH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			byte_q      <= '0;
			shift_q     <= '0;
			held_q      <= '0;
			poll_q      <= '0;
			success_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q   <= phase_nxt;
				tick_q    <= tick_nxt;
				bit_q     <= bit_nxt;
				byte_q    <= byte_nxt;
				shift_q   <= shift_nxt;
				held_q    <= held_nxt;
				poll_q    <= poll_nxt;
				success_q <= success_nxt;
			end
			out_valid_q <= in_fire | (out_valid_q & ~out_ready);
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			scl_drive_low_q <= scl_o;
			sda_drive_low_q <= sda_o;
			busy_res_q      <= busy_o;
			done_res_q      <= done_o;
			write_ok_q      <= ok_o;
		end
	end

	assign out_valid     = out_valid_q;
	assign scl_drive_low = scl_drive_low_q;
	assign sda_drive_low = sda_drive_low_q;
	assign busy_res      = busy_res_q;
	assign done_res      = done_res_q;
	assign write_ok      = write_ok_q;

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_res_q |-> busy_res_q)
		else $error("done without busy");
	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && write_ok_q |-> done_res_q)
		else $error("write_ok outside done tick");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");
	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted tick produced no result");
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_q == '0)
		else $error("tick counter not cleared in idle");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the three-byte I2C write master core.
// Needs i2c3w_pkg and i2c_three_byte_write_master_core; holds its own tick-level model.
module testbench;
	import i2c3w_pkg::*;

	// one bus tick going in, one set of line drives coming out
	typedef struct packed {
		logic       req;
		logic [7:0] addr;
		logic [7:0] regb;
		logic [7:0] data;
		logic       sda;
	} tick_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic done;
		logic ok;
	} drives_t;

	// directed row: tick, whether the drives are typed in, and the typed drives
	typedef struct packed {
		tick_t   t;
		logic    fixed;
		drives_t d;
	} row_t;

	localparam int SCRIPT_LEN      = 27;
	localparam int NUM_PHASES      = 7;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int TAIL_CYCLES     = 4;

	localparam longint unsigned TIMER_CAP  = 64'd1 << TIMER_WIDTH_DEF;
	localparam longint unsigned TIMER_MASK = TIMER_CAP - 64'd1;

	// typed expectations for the directed rows: {fixed, scl, sda, busy, done, ok}
	localparam logic [5:0] BY_MODEL   = 6'b0_00000;
	localparam logic [5:0] CHK_IDLE   = 6'b1_00000;
	localparam logic [5:0] CHK_ABORTED = 6'b1_00110;

	// random phases: timing settings, item counts and line behavior.
	// The poll limit is written as 16-bit data so the upper byte gets dropped.
	localparam int SET_LOW  [NUM_PHASES] = '{5, 1, 1, 2, 3, 1, 1};
	localparam int SET_HIGH [NUM_PHASES] = '{5, 1, 1, 1, 2, 1, 1};
	localparam int SET_HOLD [NUM_PHASES] = '{5, 1, 1, 3, 1, 65535, 2};
	localparam int SET_POLL [NUM_PHASES] = '{'h0064, 'h0001, 'h00FF, 'hAB03, 'h5402, 'h0050, 'hFF07};
	localparam int SET_ITEMS [NUM_PHASES] = '{250, 200, 290, 250, 150, 100, 150};
	localparam int SET_SDA_LOW [NUM_PHASES] = '{60, 70, 0, 45, 65, 50, 75};
	localparam int SET_REQ  [NUM_PHASES] = '{50, 60, 80, 50, 50, 100, 50};
	localparam int SET_SEND_IDLE [NUM_PHASES] = '{35, 35, 68, 68, 0, 0, 0};
	localparam int SET_RECV_IDLE [NUM_PHASES] = '{68, 68, 35, 35, 0, 0, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic    in_valid = 1'b0;
	logic    in_ready;
	tick_t   bus_in = '0;
	logic    row_fixed = 1'b0;   // travels with the tick: typed drives apply
	drives_t row_drives = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic scl_drive_low, sda_drive_low, busy_res, done_res, write_ok;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_requests = 0;
	int stalls_served = 0;
	int errors = 0;
	int quiet_cycles = 0;

	drives_t pending_drives [$];
	row_t    script [SCRIPT_LEN];

	// ---------------------------------------------------------------
	// Tick model of the master. State starts at its reset values and
	// is only touched by the scoreboard block below.
	// ---------------------------------------------------------------
	logic [TIMING_W-1:0] set_low  = SCL_LOW_RST;
	logic [TIMING_W-1:0] set_high = SCL_HIGH_RST;
	logic [TIMING_W-1:0] set_hold = START_HOLD_RST;
	logic [POLL_W-1:0]   set_poll = POLL_LIMIT_RST;

	logic [PHASE_W-1:0] ph      = PH_IDLE;
	longint unsigned    ticks   = 0;
	logic [2:0]         bit_no  = '0;
	logic [1:0]         byte_no = '0;
	logic [7:0]         shifter = '0;
	logic [15:0]        held    = '0;
	logic [7:0]         polls   = '0;
	logic               acked   = 1'b0;

	// One tick of a timed phase; true on its last tick.
	// A setting of 0 counts as 1, anything past the counter range saturates.
	function automatic logic timer_expire(input logic [TIMING_W-1:0] setting);
		longint unsigned lim;
		lim = setting;
		if (lim == 0)
			lim = 1;
		if (lim > TIMER_CAP)
			lim = TIMER_CAP;
		if (ticks + 1 >= lim) begin
			ticks = 0;
			return 1'b1;
		end
		ticks = (ticks + 1) & TIMER_MASK;
		return 1'b0;
	endfunction

	function automatic void load_byte(input logic [7:0] value);
		shifter = value;
		bit_no  = '0;
		ticks   = 0;
		ph      = PH_BIT_LOW;
	endfunction

	// Drives for this tick come from the phase held at its start.
	function automatic drives_t next_drives(input tick_t t);
		drives_t    d;
		logic       bit_zero;
		logic [7:0] poll_lim;
		d = '0;
		d.busy = 1'b1;
		bit_zero = ~shifter[7];
		case (ph)
			PH_START_HIGH: begin
				if (timer_expire(set_hold))
					ph = PH_START_LOW;
			end
			PH_START_LOW: begin
				d.sda = 1'b1;
				if (timer_expire(set_hold)) begin
					byte_no = '0;
					load_byte(shifter);
				end
			end
			PH_BIT_LOW: begin
				d.scl = 1'b1;
				d.sda = bit_zero;
				if (timer_expire(set_low))
					ph = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				d.sda = bit_zero;
				if (timer_expire(set_high)) begin
					if (bit_no >= LAST_BIT) begin
						ph = PH_ACK_LOW;
					end else begin
						bit_no  = bit_no + 3'd1;
						shifter = shifter << 1;
						ph      = PH_BIT_LOW;
					end
				end
			end
			PH_ACK_LOW: begin
				// SDA keeps the last data bit through the ack clock low time
				d.scl = 1'b1;
				d.sda = bit_zero;
				if (timer_expire(set_low)) begin
					polls = '0;
					ph    = PH_ACK_POLL;
				end
			end
			PH_ACK_POLL: begin
				poll_lim = (set_poll == '0) ? 8'd1 : set_poll;
				if (!t.sda) begin
					if (byte_no >= LAST_BYTE) begin
						acked = 1'b1;
						ticks = 0;
						ph    = PH_STOP_LOW;
					end else begin
						byte_no = byte_no + 2'd1;
						load_byte((byte_no == 2'd1) ? held[15:8] : held[7:0]);
					end
				end else begin
					polls = polls + 8'd1;
					if (polls == '0 || polls >= poll_lim) begin
						// no ack in time: skip the rest, stop still goes out
						acked = 1'b0;
						ticks = 0;
						ph    = PH_STOP_LOW;
					end
				end
			end
			PH_STOP_LOW: begin
				d.scl = 1'b1;
				if (timer_expire(set_low))
					ph = PH_STOP_HIGH;
			end
			PH_STOP_HIGH: begin
				d.sda = 1'b1;
				if (timer_expire(set_high))
					ph = PH_DONE;
			end
			PH_DONE: begin
				// a request on this tick is dropped
				d.done = 1'b1;
				d.ok   = acked;
				ph     = PH_IDLE;
				ticks  = 0;
			end
			default: begin
				// idle, and any code without a meaning
				d.busy = 1'b0;
				ph     = PH_IDLE;
				if (t.req) begin
					shifter = t.addr;
					held    = {t.regb, t.data};
					acked   = 1'b0;
					bit_no  = '0;
					byte_no = '0;
					polls   = '0;
					ticks   = 0;
					ph      = PH_START_HIGH;
				end
			end
		endcase
		return d;
	endfunction

	function automatic row_t script_row(input logic req, input logic [7:0] a,
			input logic [7:0] r, input logic [7:0] v, input logic sda,
			input logic [5:0] chk);
		return {req, a, r, v, sda, chk};
	endfunction

	// ---------------------------------------------------------------
	// Block under test
	// ---------------------------------------------------------------
	i2c_three_byte_write_master_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_request (bus_in.req),
		.address_byte  (bus_in.addr),
		.register_byte (bus_in.regb),
		.data_byte     (bus_in.data),
		.sda_in        (bus_in.sda),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scl_drive_low (scl_drive_low),
		.sda_drive_low (sda_drive_low),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.write_ok      (write_ok),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic compare_line(input string name, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t: %s expected %0b actual %0b", $time, name, want, got);
			errors++;
		end
	endtask

	// ---------------------------------------------------------------
	// Scoreboard: everything is sampled at the rising edge, where
	// inputs and outputs still hold their pre-edge values.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		drives_t want;
		if (out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				$display("%0t: result with none pending, expected none, actual %0b%0b%0b%0b%0b",
					$time, scl_drive_low, sda_drive_low, busy_res, done_res, write_ok);
				errors++;
			end else begin
				want = pending_drives.pop_front();
				compare_line("scl_drive_low", want.scl, scl_drive_low);
				compare_line("sda_drive_low", want.sda, sda_drive_low);
				compare_line("busy_res", want.busy, busy_res);
				compare_line("done_res", want.done, done_res);
				compare_line("write_ok", want.ok, write_ok);
			end
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCL_LOW:    set_low  = cfg_data;
				REG_SCL_HIGH:   set_high = cfg_data;
				REG_START_HOLD: set_hold = cfg_data;
				REG_POLL_LIMIT: set_poll = cfg_data[POLL_W-1:0];
				default: ;  // indexes past the last register are dropped
			endcase
		end
		if (in_valid && in_ready) begin
			// model always steps; typed rows replace its answer
			want = next_drives(bus_in);
			if (row_fixed)
				want = row_drives;
			pending_drives.push_back(want);
		end
	end

	// Watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result side: random back-pressure, plus a long hold-off on request
	// so the output register fills and the input stalls.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (stall_requests != stalls_served) begin
				stalls_served = stall_requests;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one tick, with random gaps in front; valid stays up until taken.
	task automatic send_tick(input tick_t t, input logic fixed, input drives_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		bus_in     <= t;
		row_fixed  <= fixed;
		row_drives <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering ticks and wait for every pending result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_drives.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		int    i;
		int    p;
		int    n;
		tick_t t;

		// Directed part, all timing at the minimum. Walks one transaction
		// with address 0xFF whose first ack times out after one sample:
		// idle, start, eight bits, ack clock, poll, stop, done, idle.
		// Byte inputs keep changing after the request to show latching.
		script = '{
			script_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, CHK_IDLE),
			script_row(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, CHK_IDLE),
			script_row(1'b1, 8'hFF, 8'h00, 8'hA5, 1'b1, CHK_IDLE),    // request taken
			script_row(1'b1, 8'h00, 8'hFF, 8'h5A, 1'b0, BY_MODEL),    // start high, req ignored
			script_row(1'b0, 8'h12, 8'h34, 8'h56, 1'b1, BY_MODEL),    // start low
			script_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, BY_MODEL),    // bit 7
			script_row(1'b1, 8'hAA, 8'h55, 8'hAA, 1'b1, BY_MODEL),
			script_row(1'b0, 8'h55, 8'hAA, 8'h55, 1'b0, BY_MODEL),    // bit 6
			script_row(1'b0, 8'h01, 8'h80, 8'h7F, 1'b1, BY_MODEL),
			script_row(1'b0, 8'hFE, 8'h7F, 8'h80, 1'b0, BY_MODEL),    // bit 5
			script_row(1'b1, 8'h0F, 8'hF0, 8'h0F, 1'b1, BY_MODEL),
			script_row(1'b0, 8'hF0, 8'h0F, 8'hF0, 1'b0, BY_MODEL),    // bit 4
			script_row(1'b0, 8'h33, 8'hCC, 8'h33, 1'b1, BY_MODEL),
			script_row(1'b0, 8'hCC, 8'h33, 8'hCC, 1'b0, BY_MODEL),    // bit 3
			script_row(1'b1, 8'h66, 8'h99, 8'h66, 1'b1, BY_MODEL),
			script_row(1'b0, 8'h99, 8'h66, 8'h99, 1'b0, BY_MODEL),    // bit 2
			script_row(1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1, BY_MODEL),
			script_row(1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, BY_MODEL),    // bit 1
			script_row(1'b1, 8'h81, 8'h18, 8'h81, 1'b1, BY_MODEL),
			script_row(1'b0, 8'h18, 8'h81, 8'h18, 1'b0, BY_MODEL),    // bit 0
			script_row(1'b0, 8'h7E, 8'hE7, 8'h7E, 1'b1, BY_MODEL),
			script_row(1'b0, 8'hE7, 8'h7E, 8'hE7, 1'b0, BY_MODEL),    // ack clock low
			script_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, BY_MODEL),    // poll high: timeout
			script_row(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, BY_MODEL),    // stop low
			script_row(1'b0, 8'h3C, 8'hC3, 8'h3C, 1'b1, BY_MODEL),    // stop high
			script_row(1'b1, 8'hC3, 8'h3C, 8'h99, 1'b0, CHK_ABORTED), // done, req ignored
			script_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, CHK_IDLE)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = SET_SEND_IDLE[0];
		recv_idle_pct = SET_RECV_IDLE[0];

		// every register at zero, which counts as one
		write_reg(REG_SCL_LOW, '0);
		write_reg(REG_SCL_HIGH, '0);
		write_reg(REG_START_HOLD, '0);
		write_reg(REG_POLL_LIMIT, '0);
		cfg_valid <= 1'b0;

		for (i = 0; i < SCRIPT_LEN; i++)
			send_tick(script[i].t, script[i].fixed, script[i].d);

		// Random phases. Settings change while a transaction may still be
		// in flight, so new timing lands mid-phase too; the 65535 hold
		// parks the master in start high until the next phase shrinks it.
		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			send_idle_pct = SET_SEND_IDLE[p];
			recv_idle_pct = SET_RECV_IDLE[p];
			write_reg(REG_SCL_LOW, CFG_DATA_W'(SET_LOW[p]));
			write_reg(REG_SCL_HIGH, CFG_DATA_W'(SET_HIGH[p]));
			write_reg(REG_START_HOLD, CFG_DATA_W'(SET_HOLD[p]));
			write_reg(REG_POLL_LIMIT, CFG_DATA_W'(SET_POLL[p]));
			// an index past the last register must change nothing
			write_reg(CFG_INDEX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom_range(0, 65535)));
			cfg_valid <= 1'b0;
			if (p == PRESSURE_PHASE)
				stall_requests++;
			for (n = 0; n < SET_ITEMS[p]; n++) begin
				t.req  = ($urandom_range(0, 99) < SET_REQ[p]);
				t.addr = 8'($urandom_range(0, 255));
				t.regb = 8'($urandom_range(0, 255));
				t.data = 8'($urandom_range(0, 255));
				t.sda  = ($urandom_range(0, 99) >= SET_SDA_LOW[p]);
				send_tick(t, 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_drives.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_drives.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
